// ===== hw/rtl/apbm_pkg.sv =====
// Shared types and constants of the assignment pair bitmap.
`timescale 1ns / 1ps

package apbm_pkg;

    // Field widths of the request and response words.
    localparam int OP_W       = 3;
    localparam int ARITY_W    = 3;
    localparam int OBJ_W      = 5;
    localparam int POS_W      = 2;
    localparam int REMAP_W    = 6;
    localparam int RANK_OUT_W = 15;

    // Configuration port.
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    // Argument fields of one atom and their per-position offsets.
    localparam int NUM_ARGS = 4;
    localparam int ARG_IX_W = 2;

    // Single rank: offset plus compressed index. Pair rank: j2*N + j1.
    localparam int J_W    = 9;
    localparam int PROD_W = J_W + CFG_W;
    localparam int RANK_W = PROD_W + 1;
    localparam int NN_W   = 2 * CFG_W;

    // The bitmap is stored as rows of 32 bits.
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_INSERT  = 3'd2,
        OP_QVERTEX = 3'd3,
        OP_QEDGE   = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT = 3'd0,
        CFG_OFF0  = 3'd1,
        CFG_OFF1  = 3'd2,
        CFG_OFF2  = 3'd3,
        CFG_OFF3  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LOOKUP,
        S_LWAIT,
        S_SETS,
        S_DRAIN,
        S_RESULT
    } state_t;

endpackage

// ===== hw/rtl/apbm_if.sv =====
// Request and response channel interfaces of the assignment pair bitmap.
`timescale 1ns / 1ps

interface apbm_in_if;
    import apbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [ARITY_W-1:0]    arity;
    logic [OBJ_W-1:0]      arg0;
    logic [OBJ_W-1:0]      arg1;
    logic [OBJ_W-1:0]      arg2;
    logic [OBJ_W-1:0]      arg3;
    logic [POS_W-1:0]      pos_a;
    logic [OBJ_W-1:0]      obj_a;
    logic [POS_W-1:0]      pos_b;
    logic [OBJ_W-1:0]      obj_b;
    logic [REMAP_W-1:0]    remap_value;
    logic                  second_used;

    modport source (
        output valid, op, arity, arg0, arg1, arg2, arg3,
               pos_a, obj_a, pos_b, obj_b, remap_value, second_used,
        input  ready
    );
    modport sink (
        input  valid, op, arity, arg0, arg1, arg2, arg3,
               pos_a, obj_a, pos_b, obj_b, remap_value, second_used,
        output ready
    );
endinterface

interface apbm_out_if;
    import apbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [RANK_OUT_W-1:0] rank_out;
    logic                  out_of_range;

    modport source (
        output valid, hit, rank_out, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, hit, rank_out, out_of_range,
        output ready
    );
endinterface

// ===== hw/rtl/assignment_pair_bitmap.sv =====
// Top level of the assignment pair bitmap: remap lookup, rank pipeline and bitmap memory.
`timescale 1ns / 1ps

// Usage
// req carries one request word per valid/ready handshake: remap load, bitmap
// clear, atom insert, vertex query or edge query. rsp returns exactly one word
// per request: hit, rank_out and out_of_range. The user must write registers on
// the cfg port (cfg_wr_en, cfg_index, cfg_wdata) only while no request is in
// flight; the block itself does not enforce this. One request is worked on at a
// time; req.ready is high only between requests.
// An insert takes longer as its arity grows; the single remap read port and
// the one read-modify-write per bitmap row set this.
// Clear: one 32-bit row is cleared per cycle.
// After reset a clearing pass runs before the first request is taken; cfg
// writes are taken during it.
// A finished response waits in the output register while the next request is
// already accepted; if rsp stays stalled, that next request waits at its end.

module assignment_pair_bitmap #(
    parameter int MAX_ARITY   = 4,
    parameter int MAX_OBJECTS = 32,
    parameter int BITMAP_BITS = 32768
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [apbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apbm_pkg::CFG_W-1:0]     cfg_wdata,
    apbm_in_if.sink                        req,
    apbm_out_if.source                     rsp
);
    import apbm_pkg::*;

    localparam int REMAP_DEPTH = MAX_ARITY * MAX_OBJECTS;
    localparam int REMAP_AW    = $clog2(REMAP_DEPTH);
    localparam int ROWS        = BITMAP_BITS / WORD_W;
    localparam int ROW_AW      = $clog2(ROWS);
    localparam int EFF_ARITY   = (MAX_ARITY < NUM_ARGS) ? MAX_ARITY : NUM_ARGS;

    // Configuration registers.
    logic [CFG_W-1:0]  n_reg;
    logic [CFG_W-1:0]  off_reg [NUM_ARGS];
    logic [NN_W-1:0]   nn_reg;

    // Remap table address of a (position, object) pair.
    function automatic logic [31:0] remap_index(input logic [POS_W-1:0] pos,
                                                input logic [OBJ_W-1:0] obj);
        return 32'(pos) * 32'(MAX_OBJECTS) + 32'(obj);
    endfunction

    function automatic logic remap_ok(input logic [POS_W-1:0] pos,
                                      input logic [OBJ_W-1:0] obj);
        return (32'(pos) < 32'(MAX_ARITY)) && (32'(obj) < 32'(MAX_OBJECTS));
    endfunction

    // Control state.
    state_t                state_reg, state_next;
    logic                  req_fire;
    logic                  out_load;
    logic                  issue;
    logic                  is_query;
    logic                  sets_done;

    // Latched request.
    op_t                   op_reg;
    logic [OBJ_W-1:0]      args_reg [NUM_ARGS];
    logic [POS_W-1:0]      pos_a_reg, pos_b_reg;
    logic [OBJ_W-1:0]      obj_a_reg, obj_b_reg;
    logic                  second_reg;
    logic [ARITY_W-1:0]    sat_arity;
    logic [ARG_IX_W-1:0]   lk_last_reg;

    // Remap lookup.
    logic [REMAP_W-1:0]    remap_mem [REMAP_DEPTH];
    logic [REMAP_W-1:0]    remap_rd_reg;
    logic [31:0]           load_addr_full;
    logic [31:0]           lk_addr_full;
    logic                  rm_we;
    logic                  rm_re;
    logic [ARG_IX_W-1:0]   lk_cnt_reg;
    logic [POS_W-1:0]      lk_pos;
    logic [OBJ_W-1:0]      lk_obj;
    logic                  lk_v_reg;
    logic [ARG_IX_W-1:0]   lk_idx_reg;
    logic                  lk_ok_reg;
    logic [POS_W-1:0]      lk_pos_reg;
    logic [J_W-1:0]        j_reg [NUM_ARGS];

    // Rank pipeline.
    logic [ARG_IX_W-1:0]   si_reg, sk_reg;
    logic [J_W-1:0]        m_hi, m_lo;
    logic                  m_single;
    logic                  m_v_reg;
    logic [PROD_W-1:0]     m_prod_reg;
    logic [J_W-1:0]        m_lo_reg;
    logic [RANK_W-1:0]     rank;
    logic [31:0]           rank_ext;
    logic                  rank_bad;
    logic                  c_v_reg;
    logic [ROW_AW-1:0]     c_row_reg;
    logic [BIT_W-1:0]      c_bit_reg;

    // Bitmap memory and write forwarding.
    logic [WORD_W-1:0]     bitmap_mem [ROWS];
    logic [WORD_W-1:0]     bitmap_rd_reg;
    logic [WORD_W-1:0]     row_data;
    logic                  bm_we;
    logic [ROW_AW-1:0]     bm_waddr;
    logic [WORD_W-1:0]     bm_wdata;
    logic                  wl_v_reg;
    logic [ROW_AW-1:0]     wl_row_reg;
    logic [WORD_W-1:0]     wl_data_reg;
    logic [ROW_AW-1:0]     clr_row_reg;
    logic                  clr_resp_reg;

    // Working result and output register.
    logic                  res_hit_reg;
    logic [RANK_OUT_W-1:0] res_rank_reg;
    logic                  res_oor_reg;
    logic                  rsp_v_reg;
    logic                  rsp_hit_reg;
    logic [RANK_OUT_W-1:0] rsp_rank_reg;
    logic                  rsp_oor_reg;

    // Configuration writes; N*N is kept registered for the range check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= CFG_W'(1);
            nn_reg  <= NN_W'(1);
            off_reg <= '{default: '0};
        end
        else
        begin
            nn_reg <= NN_W'(n_reg) * NN_W'(n_reg);
            if (cfg_wr_en)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_COUNT: n_reg      <= cfg_wdata;
                    CFG_OFF0:  off_reg[0] <= cfg_wdata;
                    CFG_OFF1:  off_reg[1] <= cfg_wdata;
                    CFG_OFF2:  off_reg[2] <= cfg_wdata;
                    CFG_OFF3:  off_reg[3] <= cfg_wdata;
                    default:   ;
                endcase
            end
        end
    end

    assign req_fire  = req.valid && req.ready;
    assign is_query  = (op_reg == OP_QVERTEX) || (op_reg == OP_QEDGE);
    assign sat_arity = (32'(req.arity) > 32'(EFF_ARITY)) ? ARITY_W'(EFF_ARITY) : req.arity;

    // Request word latch.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg      <= op_t'(req.op);
            args_reg[0] <= req.arg0;
            args_reg[1] <= req.arg1;
            args_reg[2] <= req.arg2;
            args_reg[3] <= req.arg3;
            pos_a_reg   <= req.pos_a;
            obj_a_reg   <= req.obj_a;
            pos_b_reg   <= req.pos_b;
            obj_b_reg   <= req.obj_b;
            second_reg  <= req.second_used;
            if (op_t'(req.op) == OP_INSERT)
                lk_last_reg <= ARG_IX_W'(sat_arity - ARITY_W'(1));
            else
                lk_last_reg <= ARG_IX_W'((op_t'(req.op) == OP_QEDGE) && req.second_used);
        end
    end

    // Remap load address and lookup address.
    assign load_addr_full = remap_index(req.pos_a, req.obj_a);
    assign rm_we = req_fire && (op_t'(req.op) == OP_LOAD) && remap_ok(req.pos_a, req.obj_a);

    always_comb
    begin
        lk_pos = POS_W'(lk_cnt_reg);
        lk_obj = args_reg[lk_cnt_reg];
        if (is_query)
        begin
            if (lk_cnt_reg == '0)
            begin
                lk_pos = pos_a_reg;
                lk_obj = obj_a_reg;
            end
            else
            begin
                lk_pos = pos_b_reg;
                lk_obj = obj_b_reg;
            end
        end
    end

    assign lk_addr_full = remap_index(lk_pos, lk_obj);
    assign rm_re        = (state_reg == S_LOOKUP);

    // Remap table memory.
    always_ff @(posedge clk)
    begin
        if (rm_we)
            remap_mem[load_addr_full[REMAP_AW-1:0]] <= req.remap_value;
        if (rm_re)
            remap_rd_reg <= remap_mem[lk_addr_full[REMAP_AW-1:0]];
    end

    // Lookup tracking: the read data returns in the cycle after the address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lk_v_reg <= 1'b0;
        else
            lk_v_reg <= rm_re;
    end

    always_ff @(posedge clk)
    begin
        lk_idx_reg <= lk_cnt_reg;
        lk_ok_reg  <= remap_ok(lk_pos, lk_obj);
        lk_pos_reg <= lk_pos;
        if (lk_v_reg)
            j_reg[lk_idx_reg] <= J_W'(off_reg[lk_pos_reg])
                               + J_W'(lk_ok_reg ? remap_rd_reg : REMAP_W'(0));
    end

    // Pair selection for the multiply stage.
    always_comb
    begin
        if (is_query)
        begin
            m_hi     = j_reg[1];
            m_lo     = j_reg[0];
            m_single = !((op_reg == OP_QEDGE) && second_reg);
        end
        else
        begin
            m_hi     = j_reg[sk_reg];
            m_lo     = j_reg[si_reg];
            m_single = (si_reg == sk_reg);
        end
    end

    assign sets_done = is_query || ((si_reg == lk_last_reg) && (sk_reg == lk_last_reg));

    // Multiply stage: j2 * N.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else
            m_v_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        m_lo_reg   <= m_lo;
        m_prod_reg <= m_single ? PROD_W'(0) : PROD_W'(m_hi) * PROD_W'(n_reg);
    end

    // Add and range check stage; a good rank reads its bitmap row.
    assign rank     = RANK_W'(m_prod_reg) + RANK_W'(m_lo_reg);
    assign rank_ext = 32'(rank);
    assign rank_bad = (rank >= RANK_W'(nn_reg)) || (rank_ext >= 32'(BITMAP_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else
            c_v_reg <= m_v_reg && !rank_bad;
    end

    always_ff @(posedge clk)
    begin
        c_row_reg <= rank_ext[ROW_AW+BIT_W-1:BIT_W];
        c_bit_reg <= rank[BIT_W-1:0];
    end

    // Row data with forwarding of the write made in the cycle of the read.
    assign row_data = (wl_v_reg && (wl_row_reg == c_row_reg)) ? wl_data_reg : bitmap_rd_reg;

    // Bitmap write: clearing pass, or set of one bit in the returned row.
    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            bm_we    = 1'b1;
            bm_waddr = clr_row_reg;
            bm_wdata = '0;
        end
        else
        begin
            bm_we    = c_v_reg && (op_reg == OP_INSERT);
            bm_waddr = c_row_reg;
            bm_wdata = row_data | (WORD_W'(1) << c_bit_reg);
        end
    end

    // Bitmap memory.
    always_ff @(posedge clk)
    begin
        if (bm_we)
            bitmap_mem[bm_waddr] <= bm_wdata;
        if (m_v_reg && !rank_bad)
            bitmap_rd_reg <= bitmap_mem[rank_ext[ROW_AW+BIT_W-1:BIT_W]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wl_v_reg <= 1'b0;
        else
            wl_v_reg <= bm_we;
    end

    always_ff @(posedge clk)
    begin
        wl_row_reg  <= bm_waddr;
        wl_data_reg <= bm_wdata;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    // Next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_row_reg == ROW_AW'(ROWS - 1))
                    state_next = clr_resp_reg ? S_RESULT : S_IDLE;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    unique case (op_t'(req.op))
                        OP_CLEAR:   state_next = S_CLR;
                        OP_INSERT:  state_next = (sat_arity == '0) ? S_RESULT : S_LOOKUP;
                        OP_QVERTEX: state_next = S_LOOKUP;
                        OP_QEDGE:   state_next = S_LOOKUP;
                        default:    state_next = S_RESULT;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (lk_cnt_reg == lk_last_reg)
                    state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                state_next = S_SETS;
            end
            S_SETS:
            begin
                issue = 1'b1;
                if (sets_done)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!m_v_reg && !c_v_reg)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!rsp_v_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer counters: lookup index, pair indices and clearing row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_cnt_reg   <= '0;
            si_reg       <= '0;
            sk_reg       <= '0;
            clr_row_reg  <= '0;
            clr_resp_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            lk_cnt_reg   <= '0;
            si_reg       <= '0;
            sk_reg       <= '0;
            clr_row_reg  <= '0;
            clr_resp_reg <= 1'b1;
        end
        else
        begin
            if (state_reg == S_LOOKUP)
                lk_cnt_reg <= lk_cnt_reg + ARG_IX_W'(1);
            if (state_reg == S_CLR)
                clr_row_reg <= clr_row_reg + ROW_AW'(1);
            if (issue && !sets_done)
            begin
                if (sk_reg == lk_last_reg)
                begin
                    si_reg <= si_reg + ARG_IX_W'(1);
                    sk_reg <= si_reg + ARG_IX_W'(1);
                end
                else
                begin
                    sk_reg <= sk_reg + ARG_IX_W'(1);
                end
            end
        end
    end

    // Working result of the current request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_hit_reg  <= 1'b0;
            res_rank_reg <= '0;
            res_oor_reg  <= 1'b0;
        end
        else if (req_fire)
        begin
            res_hit_reg  <= 1'b0;
            res_rank_reg <= '0;
            res_oor_reg  <= 1'b0;
        end
        else
        begin
            if (m_v_reg && rank_bad)
                res_oor_reg <= 1'b1;
            if (m_v_reg && is_query)
                res_rank_reg <= rank[RANK_OUT_W-1:0];
            if (c_v_reg && is_query)
                res_hit_reg <= row_data[c_bit_reg];
        end
    end

    // Output register; it holds a word until rsp takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_v_reg <= 1'b0;
        else if (out_load)
            rsp_v_reg <= 1'b1;
        else if (rsp.ready)
            rsp_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_hit_reg  <= res_hit_reg;
            rsp_rank_reg <= res_rank_reg;
            rsp_oor_reg  <= res_oor_reg;
        end
    end

    assign rsp.valid        = rsp_v_reg;
    assign rsp.hit          = rsp_hit_reg;
    assign rsp.rank_out     = rsp_rank_reg;
    assign rsp.out_of_range = rsp_oor_reg;

    // An out-of-range rank never reports a hit.
    a_oor_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.out_of_range))
        else $error("out-of-range response carries a hit");

    // A finished request reaches the output register when it is free.
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !rsp_v_reg) |=> rsp_v_reg)
        else $error("finished request not moved to output register");

    // A row access follows a valid multiply stage.
    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg |-> $past(m_v_reg))
        else $error("bitmap row access without a preceding rank");

    // Outside the clearing pass only inserts write the bitmap.
    a_write_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
        (bm_we && state_reg != S_CLR) |-> (op_reg == OP_INSERT))
        else $error("bitmap written by a request that is not an insert");

endmodule

// ===== tb/sv/apbm_checker.sv =====
// Scoreboard of the assignment pair bitmap: mirrors remap, ranks and bitmap, and checks every response word.
`timescale 1ns / 1ps

module apbm_checker #(
    parameter int MAX_ARITY   = 4,
    parameter int MAX_OBJECTS = 32,
    parameter int BITMAP_BITS = 32768
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [apbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apbm_pkg::CFG_W-1:0]     cfg_wdata,
    apbm_in_if                             req,
    apbm_out_if                            rsp,
    output int                             mismatch_count,
    output int                             answers_owed,
    output int                             answers_checked,
    output int                             hits_seen,
    output int                             out_of_range_seen
);
    import apbm_pkg::*;

    localparam int REMAP_DEPTH = MAX_ARITY * MAX_OBJECTS;

    typedef struct packed {
        logic                  hit;
        logic [RANK_OUT_W-1:0] rank;
        logic                  oor;
    } bitmap_answer_t;

    // Mirror of the block's state and register settings.
    logic [REMAP_W-1:0]   remap_mirror [REMAP_DEPTH];
    bit [BITMAP_BITS-1:0] member_bits;
    int unsigned          count_n;
    int unsigned          pos_offset [NUM_ARGS];

    // Answers worked out at request time, oldest first.
    bitmap_answer_t bitmap_answers [$];

    // One printed line per mismatch, and every mismatch is counted.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s is %0d, should be %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Rank of one (position, object) assignment: offset of the position plus its remap entry.
    function automatic int unsigned rank_of(input int unsigned pos, input int unsigned obj);
        int unsigned compressed;
        compressed = 0;
        if (pos < MAX_ARITY && obj < MAX_OBJECTS)
            compressed = remap_mirror[pos * MAX_OBJECTS + obj];
        return pos_offset[pos % NUM_ARGS] + compressed;
    endfunction

    function automatic bit rank_beyond(input int unsigned rank);
        return rank >= count_n * count_n || rank >= BITMAP_BITS;
    endfunction

    // Sets the bit of a rank; a rank at or past the limit is left alone and reported.
    function automatic bit mark_rank(input int unsigned rank);
        if (rank_beyond(rank))
            return 1'b0;
        member_bits[rank] = 1'b1;
        return 1'b1;
    endfunction

    // Applies the word now on the request channel and returns its answer.
    function automatic bitmap_answer_t answer_for_word();
        bitmap_answer_t   ans;
        logic [OBJ_W-1:0] atom [NUM_ARGS];
        int unsigned      n_args;
        int unsigned      i;
        int unsigned      k;
        int unsigned      j1;
        int unsigned      j2;
        int unsigned      rank;

        ans     = '0;
        atom[0] = req.arg0;
        atom[1] = req.arg1;
        atom[2] = req.arg2;
        atom[3] = req.arg3;
        case (req.op) inside
            OP_LOAD: begin
                if (req.pos_a < MAX_ARITY && req.obj_a < MAX_OBJECTS)
                    remap_mirror[req.pos_a * MAX_OBJECTS + req.obj_a] = req.remap_value;
            end
            OP_CLEAR: member_bits = '0;
            OP_INSERT: begin
                // Arity saturates; every single and every ordered pair gets its bit.
                n_args = req.arity;
                if (n_args > NUM_ARGS)
                    n_args = NUM_ARGS;
                if (n_args > MAX_ARITY)
                    n_args = MAX_ARITY;
                for (i = 0; i < n_args; i++)
                begin
                    j1 = rank_of(i, atom[i]);
                    if (!mark_rank(j1))
                        ans.oor = 1'b1;
                    for (k = i + 1; k < n_args; k++)
                    begin
                        j2 = rank_of(k, atom[k]);
                        if (!mark_rank(j2 * count_n + j1))
                            ans.oor = 1'b1;
                    end
                end
            end
            OP_QVERTEX, OP_QEDGE: begin
                rank = rank_of(req.pos_a, req.obj_a);
                if (req.op == OP_QEDGE && req.second_used)
                    rank += rank_of(req.pos_b, req.obj_b) * count_n;
                ans.rank = RANK_OUT_W'(rank);
                if (rank_beyond(rank))
                    ans.oor = 1'b1;
                else
                    ans.hit = member_bits[rank];
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Watches registers, responses and requests at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        bitmap_answer_t want;
        if (!rst_n)
        begin
            member_bits       = '0;
            count_n           = 1;
            pos_offset        = '{default: 0};
            bitmap_answers.delete();
            mismatch_count    = 0;
            answers_checked   = 0;
            hits_seen         = 0;
            out_of_range_seen = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_COUNT: count_n       = cfg_wdata;
                    CFG_OFF0:  pos_offset[0] = cfg_wdata;
                    CFG_OFF1:  pos_offset[1] = cfg_wdata;
                    CFG_OFF2:  pos_offset[2] = cfg_wdata;
                    CFG_OFF3:  pos_offset[3] = cfg_wdata;
                    default: ;
                endcase
            end

            // A response word is compared with the oldest answer still owed.
            if (rsp.valid && rsp.ready)
            begin
                if (bitmap_answers.size() == 0)
                    report_mismatch("response word with no request owed, rank_out",
                                    rsp.rank_out, 0);
                else
                begin
                    want = bitmap_answers.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", rsp.hit, want.hit);
                    if (rsp.rank_out !== want.rank)
                        report_mismatch("rank_out", rsp.rank_out, want.rank);
                    if (rsp.out_of_range !== want.oor)
                        report_mismatch("out_of_range", rsp.out_of_range, want.oor);
                    answers_checked++;
                    hits_seen         += want.hit;
                    out_of_range_seen += want.oor;
                end
            end

            if (req.valid && req.ready)
                bitmap_answers.push_back(answer_for_word());
        end
        answers_owed = bitmap_answers.size();
    end

endmodule

// ===== tb/sv/assignment_pair_bitmap_tb.sv =====
// Testbench top of the assignment pair bitmap: clock, reset, register settings and request traffic.
`timescale 1ns / 1ps

module assignment_pair_bitmap_tb;
    import apbm_pkg::*;

    localparam int MAX_ARITY    = 4;
    localparam int MAX_OBJECTS  = 32;
    localparam int BITMAP_BITS  = 32768;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 143;
    localparam int RECENT_DEPTH = 8;

    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_QEDGE + 1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;
    localparam cfg_idx_t REG_ORDER [NUM_ARGS+1] =
        '{CFG_COUNT, CFG_OFF0, CFG_OFF1, CFG_OFF2, CFG_OFF3};

    typedef logic [CFG_W-1:0] offset_set_t [NUM_ARGS];

    typedef struct packed {
        logic [OP_W-1:0]                op;
        logic [ARITY_W-1:0]             arity;
        logic [NUM_ARGS-1:0][OBJ_W-1:0] args;
        logic [POS_W-1:0]               pos_a;
        logic [OBJ_W-1:0]               obj_a;
        logic [POS_W-1:0]               pos_b;
        logic [OBJ_W-1:0]               obj_b;
        logic [REMAP_W-1:0]             remap_value;
        logic                           second_used;
    } bitmap_word_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    bit idling_on      = 1'b0;
    int words_sent     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    int mismatch_count;
    int answers_owed;
    int answers_checked;
    int hits_seen;
    int out_of_range_seen;

    // Recently inserted atoms, so that queries can aim at bits that are set.
    logic [NUM_ARGS-1:0][OBJ_W-1:0] recent_args  [RECENT_DEPTH];
    logic [ARITY_W-1:0]             recent_arity [RECENT_DEPTH];
    int                             recent_fill = 0;
    int                             recent_next = 0;

    apbm_in_if  req_ch ();
    apbm_out_if rsp_ch ();

    assignment_pair_bitmap #(
        .MAX_ARITY   (MAX_ARITY),
        .MAX_OBJECTS (MAX_OBJECTS),
        .BITMAP_BITS (BITMAP_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    apbm_checker #(
        .MAX_ARITY   (MAX_ARITY),
        .MAX_OBJECTS (MAX_OBJECTS),
        .BITMAP_BITS (BITMAP_BITS)
    ) bitmap_mirror (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .mismatch_count    (mismatch_count),
        .answers_owed      (answers_owed),
        .answers_checked   (answers_checked),
        .hits_seen         (hits_seen),
        .out_of_range_seen (out_of_range_seen)
    );

    always #5 clk = ~clk;

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d answers owed", cycle_count,
                     answers_owed);
            $display("Some tests failed");
            $finish;
        end
    end

    // The response side stalls in short random bursts while idling is enabled.
    initial
    begin
        rsp_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
        end
    end

    // A word with every field random apart from the operation.
    function automatic bitmap_word_t noise_word(input logic [OP_W-1:0] op);
        bitmap_word_t w;
        w.op          = op;
        w.arity       = $urandom_range(0, 7);
        w.args[0]     = $urandom_range(0, 31);
        w.args[1]     = $urandom_range(0, 31);
        w.args[2]     = $urandom_range(0, 31);
        w.args[3]     = $urandom_range(0, 31);
        w.pos_a       = $urandom_range(0, 3);
        w.obj_a       = $urandom_range(0, 31);
        w.pos_b       = $urandom_range(0, 3);
        w.obj_b       = $urandom_range(0, 31);
        w.remap_value = $urandom_range(0, 32);
        w.second_used = $urandom_range(0, 1);
        return w;
    endfunction

    // Presents one word, waits for its handshake and maybe idles afterwards.
    task automatic send_word(input bitmap_word_t w);
        req_ch.op          = w.op;
        req_ch.arity       = w.arity;
        req_ch.arg0        = w.args[0];
        req_ch.arg1        = w.args[1];
        req_ch.arg2        = w.args[2];
        req_ch.arg3        = w.args[3];
        req_ch.pos_a       = w.pos_a;
        req_ch.obj_a       = w.obj_a;
        req_ch.pos_b       = w.pos_b;
        req_ch.obj_b       = w.obj_b;
        req_ch.remap_value = w.remap_value;
        req_ch.second_used = w.second_used;
        req_ch.valid       = 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        @(negedge clk);
        words_sent++;
        if (w.op == OP_INSERT && w.arity != 0)
        begin
            recent_args[recent_next]  = w.args;
            recent_arity[recent_next] = w.arity;
            recent_next = (recent_next + 1) % RECENT_DEPTH;
            if (recent_fill < RECENT_DEPTH)
                recent_fill++;
        end
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    // Holds off new words until every answer has come back.
    task automatic settle();
        req_ch.valid = 1'b0;
        while (answers_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] n, input offset_set_t offs);
        int i;
        settle();
        for (i = 0; i <= NUM_ARGS; i++)
        begin
            cfg_wr_en = 1'b1;
            cfg_index = REG_ORDER[i];
            cfg_wdata = (i == 0) ? n : offs[i - 1];
            @(negedge clk);
        end
        cfg_wr_en = 1'b0;
        settings_used++;
    endtask

    // Mostly inserts and queries; most queries aim at a recently inserted atom.
    task automatic pick_random_word(output bitmap_word_t w);
        int roll;
        int h;
        int a;
        int i;
        int k;
        roll = $urandom_range(0, 99);
        w    = noise_word(OP_LOAD);
        if (roll < 7)
            w.op = OP_LOAD;
        else if (roll < 8)
            w.op = OP_CLEAR;
        else if (roll < 43)
        begin
            w.op    = OP_INSERT;
            w.arity = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7)
                                                   : $urandom_range(0, 4);
        end
        else if (roll < 97)
        begin
            w.op = (roll < 70) ? OP_QVERTEX : OP_QEDGE;
            if (recent_fill > 0 && $urandom_range(0, 9) < 6)
            begin
                h = $urandom_range(0, recent_fill - 1);
                a = (recent_arity[h] > NUM_ARGS) ? NUM_ARGS : recent_arity[h];
                i = $urandom_range(0, a - 1);
                w.pos_a = i;
                w.obj_a = recent_args[h][i];
                if (w.op == OP_QEDGE && a > 1)
                begin
                    i = $urandom_range(0, a - 2);
                    k = $urandom_range(i + 1, a - 1);
                    w.pos_a       = i;
                    w.obj_a       = recent_args[h][i];
                    w.pos_b       = k;
                    w.obj_b       = recent_args[h][k];
                    w.second_used = 1'b1;
                end
            end
        end
        else
            w.op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
    endtask

    // One register setting followed by random traffic, with a full drain half way.
    task automatic run_phase(input logic [CFG_W-1:0] n, input offset_set_t offs,
                             input bit idles);
        bitmap_word_t w;
        int i;
        configure(n, offs);
        idling_on = idles;
        for (i = 0; i < PHASE_WORDS; i++)
        begin
            if (i == PHASE_WORDS / 2)
                settle();
            pick_random_word(w);
            send_word(w);
        end
    endtask

    initial
    begin
        bitmap_word_t w;
        offset_set_t  offs;
        int           p;
        int           o;

        req_ch.valid       = 1'b0;
        req_ch.op          = '0;
        req_ch.arity       = '0;
        req_ch.arg0        = '0;
        req_ch.arg1        = '0;
        req_ch.arg2        = '0;
        req_ch.arg3        = '0;
        req_ch.pos_a       = '0;
        req_ch.obj_a       = '0;
        req_ch.pos_b       = '0;
        req_ch.obj_b       = '0;
        req_ch.remap_value = '0;
        req_ch.second_used = 1'b0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Fill the whole remap table first, so that no lookup reads an unloaded entry.
        configure(8'd133, '{8'd0, 8'd33, 8'd66, 8'd99});
        idling_on = 1'b1;
        for (p = 0; p < MAX_ARITY; p++)
            for (o = 0; o < MAX_OBJECTS; o++)
            begin
                w = noise_word(OP_LOAD);
                w.pos_a = p;
                w.obj_a = o;
                send_word(w);
            end
        idling_on = 1'b0;

        // Directed words: load extremes, every arity from zero to four and the saturated arities five and seven.
        w = noise_word(OP_LOAD);
        w.pos_a = 0; w.obj_a = 0; w.remap_value = 0;
        send_word(w);
        w = noise_word(OP_LOAD);
        w.pos_a = 3; w.obj_a = 31; w.remap_value = 32;
        send_word(w);
        w = noise_word(OP_LOAD);
        w.pos_a = 1; w.obj_a = 31; w.remap_value = 17;
        send_word(w);
        w = noise_word(OP_INSERT);
        w.arity = 0;
        send_word(w);
        w = noise_word(OP_INSERT);
        w.arity = 4; w.args = {5'd31, 5'd0, 5'd31, 5'd0};
        send_word(w);
        w = noise_word(OP_INSERT);
        w.arity = 7; w.args = {5'd0, 5'd31, 5'd0, 5'd31};
        send_word(w);
        w = noise_word(OP_INSERT);
        w.arity = 5;
        send_word(w);
        w = noise_word(OP_INSERT);
        w.arity = 1; w.args[0] = 31;
        send_word(w);
        w = noise_word(OP_INSERT);
        w.arity = 2;
        send_word(w);
        w = noise_word(OP_INSERT);
        w.arity = 3;
        send_word(w);

        // Queries of both kinds, with and without a second assignment.
        w = noise_word(OP_QVERTEX);
        w.pos_a = 0; w.obj_a = 0;
        send_word(w);
        w = noise_word(OP_QVERTEX);
        w.pos_a = 3; w.obj_a = 31;
        send_word(w);
        w = noise_word(OP_QEDGE);
        w.pos_a = 0; w.obj_a = 0; w.pos_b = 1; w.obj_b = 31; w.second_used = 1'b1;
        send_word(w);
        w = noise_word(OP_QEDGE);
        w.pos_a = 0; w.obj_a = 31; w.second_used = 1'b0;
        send_word(w);
        w = noise_word(OP_QEDGE);
        w.pos_a = 3; w.obj_a = 31; w.pos_b = 3; w.obj_b = 31; w.second_used = 1'b1;
        send_word(w);

        // Unknown codes change nothing; then a clear and two of the same queries again.
        for (p = OP_SPARE_LO; p <= OP_SPARE_HI; p++)
            send_word(noise_word(p));
        send_word(noise_word(OP_CLEAR));
        w = noise_word(OP_QVERTEX);
        w.pos_a = 0; w.obj_a = 0;
        send_word(w);
        w = noise_word(OP_QEDGE);
        w.pos_a = 0; w.obj_a = 0; w.pos_b = 1; w.obj_b = 31; w.second_used = 1'b1;
        send_word(w);

        // Random traffic over several settings, with N from zero up to 133.
        run_phase(8'd133, '{8'd132, 8'd132, 8'd132, 8'd132}, 1'b1);
        run_phase(8'd1, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1);
        run_phase(8'd12, '{8'd0, 8'd3, 8'd6, 8'd9}, 1'b0);
        run_phase(8'd0, '{8'd5, 8'd0, 8'd132, 8'd1}, 1'b1);
        for (p = 0; p < NUM_ARGS; p++)
            offs[p] = $urandom_range(0, 132);
        run_phase($urandom_range(1, 133), offs, 1'b1);
        run_phase(8'd40, '{8'd0, 8'd1, 8'd2, 8'd3}, 1'b1);
        run_phase(8'd133, '{8'd0, 8'd33, 8'd66, 8'd99}, 1'b0);

        settle();
        repeat (20) @(negedge clk);

        $display("Sent %0d request words over %0d register settings; %0d responses checked.",
                 words_sent, settings_used, answers_checked);
        $display("Responses held %0d hits and %0d ranks out of range.",
                 hits_seen, out_of_range_seen);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/apbm_pkg.sv
hw/rtl/apbm_if.sv
hw/rtl/assignment_pair_bitmap.sv
tb/sv/apbm_checker.sv
tb/sv/assignment_pair_bitmap_tb.sv
